// ----- rtl/core/wsd_pkg.sv -----
// Shared types and constants of the WebSocket text frame deframer.
package wsd_pkg;

    localparam int OUT_DEPTH_DEFAULT = 4;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_PONG    = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [3:0] OPC_TEXT = 4'h1;
    localparam logic [3:0] OPC_PING = 4'h9;

    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    localparam logic [7:0] PONG_BYTE0 = 8'h8a;
    localparam logic [7:0] PONG_BYTE1 = 8'h00;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1_TEXT,
        PH_HDR1_PING,
        PH_HDR1_OTHER,
        PH_EXTLEN,
        PH_KEY,
        PH_PAYLOAD
    } t_phase;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       last;
    } t_result;

    typedef struct packed {
        logic    valid0;
        logic    valid1;
        t_result res0;
        t_result res1;
    } t_emit;

endpackage

// ----- rtl/core/wsd_parser.sv -----
// Byte-wise frame header parser and payload unmasker.
module wsd_parser
    import wsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_rx_byte,
    output t_emit      o_emit
);

    t_phase      r_phase, n_phase;
    logic        r_mask, n_mask;
    logic [63:0] r_len, n_len;
    logic [3:0]  r_cnt, n_cnt;
    logic [63:0] r_rem, n_rem;
    logic [1:0]  r_kidx, n_kidx;
    logic [7:0]  r_key [4];

    logic        w_key_we;
    logic [1:0]  w_key_sel;
    logic        w_len_done;
    logic [63:0] w_len;
    logic [3:0]  w_cnt_dec;
    logic [7:0]  w_data;
    logic        w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR0;
            r_mask  <= 1'b0;
            r_cnt   <= 4'd0;
            r_kidx  <= 2'd0;
        end else begin
            r_phase <= n_phase;
            r_mask  <= n_mask;
            r_cnt   <= n_cnt;
            r_kidx  <= n_kidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= n_len;
        r_rem <= n_rem;
        if (w_key_we) begin
            r_key[w_key_sel] <= i_rx_byte;
        end
    end

    assign w_cnt_dec = r_cnt - 4'd1;
    assign w_key_sel = 2'(4'd0 - r_cnt);
    assign w_data    = i_rx_byte ^ (r_mask ? r_key[r_kidx] : 8'h00);
    assign w_last    = (r_rem == 64'd1);

    always_comb begin
        n_phase    = r_phase;
        n_mask     = r_mask;
        n_len      = r_len;
        n_cnt      = r_cnt;
        n_rem      = r_rem;
        n_kidx     = r_kidx;
        w_key_we   = 1'b0;
        w_len_done = 1'b0;
        w_len      = r_len;
        o_emit     = '0;
        if (i_take) begin
            case (r_phase)
                PH_HDR0: begin
                    if (i_rx_byte[3:0] == OPC_TEXT) begin
                        n_phase = PH_HDR1_TEXT;
                    end else if (i_rx_byte[3:0] == OPC_PING) begin
                        n_phase = PH_HDR1_PING;
                    end else begin
                        n_phase = PH_HDR1_OTHER;
                    end
                end
                PH_HDR1_TEXT: begin
                    n_mask = i_rx_byte[7];
                    if (i_rx_byte[6:0] == LEN_CODE_16) begin
                        n_len   = 64'd0;
                        n_cnt   = 4'd2;
                        n_phase = PH_EXTLEN;
                    end else if (i_rx_byte[6:0] == LEN_CODE_64) begin
                        n_len   = 64'd0;
                        n_cnt   = 4'd8;
                        n_phase = PH_EXTLEN;
                    end else begin
                        w_len      = {57'd0, i_rx_byte[6:0]};
                        n_len      = w_len;
                        w_len_done = 1'b1;
                    end
                end
                PH_HDR1_PING: begin
                    n_phase        = PH_HDR0;
                    o_emit.valid0  = 1'b1;
                    o_emit.valid1  = 1'b1;
                    o_emit.res0    = '{data: PONG_BYTE0, kind: KIND_PONG, last: 1'b0};
                    o_emit.res1    = '{data: PONG_BYTE1, kind: KIND_PONG, last: 1'b1};
                end
                PH_HDR1_OTHER: begin
                    n_phase = PH_HDR0;
                end
                PH_EXTLEN: begin
                    w_len = {r_len[55:0], i_rx_byte};
                    n_len = w_len;
                    n_cnt = w_cnt_dec;
                    if (w_cnt_dec == 4'd0) begin
                        w_len_done = 1'b1;
                    end
                end
                PH_KEY: begin
                    w_key_we = 1'b1;
                    n_cnt    = w_cnt_dec;
                    if (w_cnt_dec == 4'd0) begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    n_rem         = r_rem - 64'd1;
                    n_kidx        = r_kidx + 2'd1;
                    o_emit.valid0 = 1'b1;
                    o_emit.res0   = '{data: w_data, kind: KIND_PAYLOAD, last: w_last};
                    if (w_last) begin
                        n_phase = PH_HDR0;
                    end
                end
                default: begin
                    n_phase = PH_HDR0;
                end
            endcase

            // Length known: a zero length reports an error, otherwise the key or
            // the payload follows.
            if (w_len_done) begin
                if (w_len == 64'd0) begin
                    n_phase       = PH_HDR0;
                    o_emit.valid0 = 1'b1;
                    o_emit.res0   = '{data: 8'h00, kind: KIND_ERROR, last: 1'b0};
                end else begin
                    n_rem  = w_len;
                    n_kidx = 2'd0;
                    if (n_mask) begin
                        n_cnt   = 4'd4;
                        n_phase = PH_KEY;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
        end
    end

endmodule

// ----- rtl/core/wsd_out_fifo.sv -----
// Result queue that takes up to two words per cycle and hands out one.
module wsd_out_fifo
    import wsd_pkg::*;
#(
    parameter int DEPTH = OUT_DEPTH_DEFAULT
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_emit   i_emit,
    output logic    o_room2,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_result       r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          w_pop;
    logic [PW-1:0] w_wr1;

    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rd];
    assign o_room2 = (r_count <= CW'(DEPTH - 2));
    assign w_pop   = o_valid && i_ready;
    assign w_wr1   = r_wr + PW'(1);

    always_comb begin
        n_wr    = r_wr + PW'(i_emit.valid0) + PW'(i_emit.valid1);
        n_rd    = r_rd + PW'(w_pop);
        n_count = r_count + CW'(i_emit.valid0) + CW'(i_emit.valid1) - CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_emit.valid0) begin
            r_mem[r_wr] <= i_emit.res0;
        end
        if (i_emit.valid1) begin
            r_mem[w_wr1] <= i_emit.res1;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("Result queue count exceeds its depth.");

    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_emit.valid1 |-> i_emit.valid0)
        else $error("Second result pushed without a first one.");

    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_emit.valid0 && i_emit.valid1) |-> (r_count <= CW'(DEPTH - 2)))
        else $error("Pair of results pushed into a queue without room.");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !i_emit.valid0) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("Result queue count did not drop after a lone pop.");

endmodule

// ----- rtl/core/websocket_text_frame_deframer_unit.sv -----
// Top level of the WebSocket text frame deframer.
//
// The block takes one received byte per clock cycle while rx_ready is high and
// presents the results it causes from the cycle after, through a four-entry
// result queue: one payload byte (unmasked with the frame key), a zero length
// error, or, for a ping header, the two pong bytes. Every byte is parsed in a
// single pass of the header/length/key state machine, so with out_ready held
// high the sustained rate is one byte per cycle. rx_ready drops only when the
// queue has fewer than two free entries. While link_open is zero, bytes are
// still taken but are dropped and leave the parser state unchanged.
module websocket_text_frame_deframer_unit
    import wsd_pkg::*;
#(
    parameter int OUT_DEPTH = OUT_DEPTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_out_kind,
    output logic       o_out_last
);

    logic    r_link_open;
    logic    w_take;
    logic    w_room2;
    t_emit   w_emit;
    t_result w_res;

    assign o_cfg_ready = 1'b1;
    assign o_rx_ready  = w_room2;
    assign w_take      = i_rx_valid && o_rx_ready && r_link_open;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_open <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_link_open <= i_cfg_data;
        end
    end

    wsd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (w_take),
        .i_rx_byte (i_rx_byte),
        .o_emit    (w_emit)
    );

    wsd_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (w_emit),
        .o_room2 (w_room2),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (w_res)
    );

    assign o_out_byte = w_res.data;
    assign o_out_kind = w_res.kind;
    assign o_out_last = w_res.last;

endmodule

// ----- bench/websocket_text_frame_deframer_unit_tb.sv -----
// Self-checking testbench for the WebSocket text frame deframer unit.
`timescale 1ns / 100ps

module websocket_text_frame_deframer_unit_tb
    import wsd_pkg::*;
();

    typedef enum int {
        SEL_LEN7,
        SEL_LEN16,
        SEL_LEN64
    } t_len_form;

    class t_scoreboard;
        bit          link_open;
        t_phase      phase;
        bit          masked;
        logic [63:0] frame_len;
        logic [3:0]  field_left;
        logic [7:0]  key [4];
        logic [63:0] pay_idx;
        t_result     expected_words [$];
        int          errors;

        function new();
            link_open  = 1'b0;
            phase      = PH_HDR0;
            masked     = 1'b0;
            frame_len  = '0;
            field_left = '0;
            pay_idx    = '0;
            errors     = 0;
            for (int i = 0; i < 4; i++) begin
                key[i] = 8'h00;
            end
        endfunction

        function void push_word(logic [7:0] d, logic [1:0] k, logic l);
            t_result w;
            w.data = d;
            w.kind = k;
            w.last = l;
            expected_words.push_back(w);
        endfunction

        function void length_known();
            if (frame_len == 64'd0) begin
                phase = PH_HDR0;
                push_word(8'h00, KIND_ERROR, 1'b0);
            end else begin
                pay_idx = '0;
                if (masked) begin
                    field_left = 4'd4;
                    phase      = PH_KEY;
                end else begin
                    phase = PH_PAYLOAD;
                end
            end
        endfunction

        function void take_rx_byte(logic [7:0] b);
            logic [3:0] slot;
            logic [7:0] v;
            logic       last;
            if (!link_open) begin
                return;
            end
            case (phase)
                PH_HDR0: begin
                    if (b[3:0] == OPC_TEXT) begin
                        phase = PH_HDR1_TEXT;
                    end else if (b[3:0] == OPC_PING) begin
                        phase = PH_HDR1_PING;
                    end else begin
                        phase = PH_HDR1_OTHER;
                    end
                end
                PH_HDR1_TEXT: begin
                    masked = b[7];
                    if (b[6:0] == LEN_CODE_16) begin
                        frame_len  = '0;
                        field_left = 4'd2;
                        phase      = PH_EXTLEN;
                    end else if (b[6:0] == LEN_CODE_64) begin
                        frame_len  = '0;
                        field_left = 4'd8;
                        phase      = PH_EXTLEN;
                    end else begin
                        frame_len = {57'd0, b[6:0]};
                        length_known();
                    end
                end
                PH_HDR1_PING: begin
                    phase = PH_HDR0;
                    push_word(PONG_BYTE0, KIND_PONG, 1'b0);
                    push_word(PONG_BYTE1, KIND_PONG, 1'b1);
                end
                PH_HDR1_OTHER: begin
                    phase = PH_HDR0;
                end
                PH_EXTLEN: begin
                    frame_len  = {frame_len[55:0], b};
                    field_left = field_left - 4'd1;
                    if (field_left == 4'd0) begin
                        length_known();
                    end
                end
                PH_KEY: begin
                    slot            = 4'd4 - field_left;
                    key[slot[1:0]]  = b;
                    field_left      = field_left - 4'd1;
                    if (field_left == 4'd0) begin
                        phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    v       = masked ? (b ^ key[pay_idx[1:0]]) : b;
                    last    = (pay_idx == frame_len - 64'd1);
                    pay_idx = pay_idx + 64'd1;
                    if (last) begin
                        phase = PH_HDR0;
                    end
                    push_word(v, KIND_PAYLOAD, last);
                end
                default: begin
                    phase = PH_HDR0;
                end
            endcase
        endfunction

        task report(string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            errors++;
        endtask

        task match_out_word(logic [7:0] d, logic [1:0] k, logic l);
            t_result w;
            if (expected_words.size() == 0) begin
                report($sformatf("unexpected word byte=%h kind=%0d last=%0d", d, k, l));
                return;
            end
            w = expected_words.pop_front();
            if (d !== w.data) begin
                report($sformatf("byte %h, expected %h", d, w.data));
            end
            if (k !== w.kind) begin
                report($sformatf("kind %0d, expected %0d", k, w.kind));
            end
            if (l !== w.last) begin
                report($sformatf("last %0d, expected %0d", l, w.last));
            end
        endtask
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       i_cfg_data  = 1'b0;
    logic       i_rx_valid  = 1'b0;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_out_ready = 1'b1;
    logic       o_cfg_ready;
    logic       o_rx_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic [1:0] o_out_kind;
    logic       o_out_last;

    t_scoreboard sb;

    bit quiet     = 1'b0;
    int rx_odds   = 6;
    int out_odds  = 6;
    int out_stall = 0;
    int n_fed     = 0;

    websocket_text_frame_deframer_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_rx_valid  (i_rx_valid),
        .o_rx_ready  (o_rx_ready),
        .i_rx_byte   (i_rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_out_kind  (o_out_kind),
        .o_out_last  (o_out_last)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    initial begin
        #20000000;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (quiet || out_odds == 0) begin
            out_stall = 0;
        end else if (out_stall == 0 && $urandom_range(1, out_odds) == 1) begin
            out_stall = $urandom_range(1, 19);
        end
        if (out_stall > 0) begin
            out_stall = out_stall - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.match_out_word(o_out_byte, o_out_kind, o_out_last);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (!quiet && rx_odds != 0 && $urandom_range(1, rx_odds) == 1) begin
            gap = $urandom_range(1, 19);
        end
        if (gap > 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        sb.take_rx_byte(b);
        if (sb.link_open) begin
            n_fed++;
        end
    endtask

    task automatic drain();
        i_rx_valid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic v);
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid  <= 1'b0;
        sb.link_open = v;
    endtask

    task automatic link_closed_burst(input int n);
        drain();
        cfg_write(1'b0);
        repeat (n) send_byte(8'($urandom));
        drain();
        cfg_write(1'b1);
    endtask

    task automatic send_text(input bit m, input t_len_form form, input logic [63:0] len,
                             input int n_pay);
        send_byte({4'($urandom), OPC_TEXT});
        case (form)
            SEL_LEN7: begin
                send_byte({m, len[6:0]});
            end
            SEL_LEN16: begin
                send_byte({m, LEN_CODE_16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            default: begin
                send_byte({m, LEN_CODE_64});
                for (int i = 7; i >= 0; i--) begin
                    send_byte(len[8*i +: 8]);
                end
            end
        endcase
        if (len != 64'd0) begin
            if (!quiet && $urandom_range(0, 39) == 0) begin
                link_closed_burst($urandom_range(1, 6));
            end
            if (m) begin
                repeat (4) send_byte(8'($urandom));
            end
            repeat (n_pay) send_byte(8'($urandom));
        end
    endtask

    task automatic send_other();
        logic [3:0] op;
        do begin
            op = 4'($urandom);
        end while (op == OPC_TEXT || op == OPC_PING);
        send_byte({4'($urandom), op});
        send_byte(8'($urandom));
    endtask

    initial begin
        int        pick;
        int        len;
        t_len_form form;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Bytes sent before the link opens must be dropped.
        send_byte(8'h81);
        send_byte(8'h05);
        drain();
        cfg_write(1'b1);

        send_byte(8'h89);
        send_byte(8'hff);
        send_byte(8'h8a);
        send_byte(8'h80);
        send_byte(8'h81);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(LEN_CODE_16);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hf1);
        send_byte(8'hff);
        repeat (8) send_byte(8'h00);
        send_byte(8'h81);
        send_byte(8'h82);
        link_closed_burst(3);
        send_byte(8'hff);
        send_byte(8'h00);
        send_byte(8'h5a);
        send_byte(8'ha5);
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h01);
        send_byte(8'h03);
        send_byte(8'h00);
        send_byte(8'h7f);
        send_byte(8'hff);
        drain();

        while (n_fed < 1950) begin
            if (n_fed > 1750) begin
                quiet = 1'b1;
            end
            if ($urandom_range(0, 29) == 0) begin
                case ($urandom_range(0, 2))
                    0: rx_odds = 0;
                    1: rx_odds = 3;
                    default: rx_odds = 12;
                endcase
                case ($urandom_range(0, 2))
                    0: out_odds = 0;
                    1: out_odds = 3;
                    default: out_odds = 12;
                endcase
            end
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: begin
                        form = SEL_LEN7;
                        len  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 125)
                                                             : $urandom_range(1, 12);
                    end
                    5: begin
                        form = SEL_LEN7;
                        len  = 0;
                    end
                    6, 7, 8: begin
                        form = SEL_LEN16;
                        len  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 300);
                    end
                    default: begin
                        form = SEL_LEN64;
                        len  = $urandom_range(0, 20);
                    end
                endcase
                send_text(1'($urandom_range(0, 1)), form, 64'(len), len);
            end else if (pick < 78) begin
                send_byte({4'($urandom), OPC_PING});
                send_byte(8'($urandom));
            end else if (pick < 92) begin
                send_other();
            end else if (pick < 96 && !quiet) begin
                link_closed_burst($urandom_range(1, 10));
            end else if (!quiet) begin
                drain();
            end
        end

        // A 64-bit length with its top bit set never reaches its last byte here.
        send_text(1'b1, SEL_LEN64, 64'h8000_0000_0000_0003, 40);

        i_rx_valid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
